/* rtl/chs_pkg.sv */
package chs_pkg;

    localparam int BUCKETS          = 16;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int TOTAL_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;

    localparam int KEY_W    = 31;
    localparam int CFG_W    = 5;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int SLOT_W   = $clog2(SLOTS_PER_BUCKET);
    localparam int ADDR_W   = $clog2(TOTAL_SLOTS);
    localparam int IDX_W    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int CNT_W    = 4;
    localparam int MODCNT_W = $clog2(KEY_W);

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(7);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] removed_count;
        logic             status;
    } rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              clr_en;
        logic [ADDR_W-1:0] wr_addr;
    } slot_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_SCAN
    } state_t;

endpackage

/* rtl/chs_mod.sv */
module chs_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [chs_pkg::KEY_W-1:0]     key,
    input  logic [chs_pkg::CFG_W-1:0]     divisor,
    output logic                          done,
    output logic [chs_pkg::BUCKET_W-1:0]  remainder
);
    import chs_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [MODCNT_W-1:0]   cnt_reg, cnt_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [CFG_W-1:0]      div_reg, div_next;
    logic [BUCKET_W-1:0]   rem_reg, rem_next;
    logic [CFG_W-1:0]      shifted;
    logic [CFG_W-1:0]      diff;

    assign shifted = {rem_reg, key_reg[KEY_W-1]};
    assign diff    = shifted - div_reg;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = MODCNT_W'(KEY_W - 1);
            key_next = key;
            div_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            key_next = {key_reg[KEY_W-2:0], 1'b0};
            if (shifted >= div_reg)
                rem_next = diff[BUCKET_W-1:0];
            else
                rem_next = shifted[BUCKET_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/chs_store.sv */
module chs_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  chs_pkg::slot_cmd_t         cmd,
    input  logic [chs_pkg::KEY_W-1:0]  wr_key,
    output logic [chs_pkg::KEY_W-1:0]  rd_key,
    output logic                       rd_valid
);
    import chs_pkg::*;

    logic [KEY_W-1:0]       slot_key [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] valid_reg;
    logic [KEY_W-1:0]       rd_key_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            slot_key[cmd.wr_addr] <= wr_key;
        if (cmd.rd_en)
            rd_key_reg <= slot_key[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
                valid_reg[cmd.wr_addr] <= 1'b1;
            else if (cmd.clr_en)
                valid_reg[cmd.wr_addr] <= 1'b0;
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[cmd.rd_addr];
        end
    end

    assign rd_key   = rd_key_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* rtl/chained_hash_set.sv */
// Each beat runs a 31-step key modulo by the bucket count, then one slot read
// per cycle over 8 slots. A new beat is taken only while idle;
// busy stays high until the result beat.
// The result beat is shown for one cycle with done; the receiver cannot stall.
// Reset clears all slot valid bits at once and sets bucket_count to 7.
module chained_hash_set (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [chs_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       start,
    input  chs_pkg::req_t              req,
    output logic                       busy,
    output logic                       done,
    output chs_pkg::rsp_t              result
);
    import chs_pkg::*;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     bucket_count_reg;
    logic [CFG_W-1:0]     divisor;
    logic                 accept;
    logic                 mod_done;
    logic [BUCKET_W-1:0]  mod_rem;
    logic [1:0]           req_type_reg, req_type_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [BUCKET_W-1:0]  bucket_reg, bucket_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                 placed_reg, placed_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    rsp_t                 result_reg, result_next;
    slot_cmd_t            cmd;
    logic [KEY_W-1:0]     rd_key;
    logic                 rd_valid;
    logic                 hit;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        if (bucket_count_reg == '0)
            divisor = CFG_W'(1);
        else if (bucket_count_reg > CFG_W'(BUCKETS))
            divisor = CFG_W'(BUCKETS);
        else
            divisor = bucket_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_count_reg <= BUCKET_COUNT_RESET;
        else if (cfg_we)
            bucket_count_reg <= cfg_wdata;
    end

    chs_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .key       (req.key),
        .divisor   (divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    chs_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_key   (key_reg),
        .rd_key   (rd_key),
        .rd_valid (rd_valid)
    );

    assign hit = rd_valid && (rd_key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        req_type_next  = req_type_reg;
        key_next       = key_reg;
        bucket_next    = bucket_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        placed_next    = placed_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_type_next = req.req_type;
                    key_next      = req.key;
                    state_next    = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (mod_done)
                begin
                    bucket_next = mod_rem;
                    idx_next    = '0;
                    placed_next = 1'b0;
                    found_next  = 1'b0;
                    cnt_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg != IDX_W'(SLOTS_PER_BUCKET))
                begin
                    cmd.rd_en      = 1'b1;
                    cmd.rd_addr    = {bucket_reg, idx_reg[SLOT_W-1:0]};
                    pend_next      = 1'b1;
                    pend_addr_next = cmd.rd_addr;
                    idx_next       = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    cmd.wr_addr = pend_addr_reg;
                    case (req_type_reg)
                        REQ_INSERT:
                        begin
                            if (!rd_valid && !placed_reg)
                            begin
                                cmd.wr_en   = 1'b1;
                                placed_next = 1'b1;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (hit)
                                found_next = 1'b1;
                        end
                        REQ_REMOVE:
                        begin
                            if (hit)
                            begin
                                cmd.clr_en = 1'b1;
                                if (cnt_reg != '1)
                                    cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (idx_reg == IDX_W'(SLOTS_PER_BUCKET) && !pend_reg)
                begin
                    result_next.found         = found_reg;
                    result_next.removed_count = cnt_reg;
                    result_next.status        = (req_type_reg == REQ_INSERT) && !placed_reg;
                    done_next                 = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        key_reg       <= key_next;
        bucket_reg    <= bucket_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        placed_reg    <= placed_next;
        found_reg     <= found_next;
        cnt_reg       <= cnt_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("done without a finished beat");

    a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.clr_en))
        else $error("slot written and cleared together");

    a_remove_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.removed_count != '0) |-> req_type_reg == REQ_REMOVE)
        else $error("removed_count set on a non-remove beat");

endmodule
